// ===== design/kgrr_pkg.sv =====
// ----------------------------------------------------------------------------
// kgrr_pkg
// Shared types and constants for the k-group reversal reorder block:
// channel payloads, controller state and the controller/datapath command bus.
// ----------------------------------------------------------------------------
package kgrr_pkg;

   // fixed field widths
   localparam int DATA_W = 32;
   localparam int CFG_W  = 7;
   localparam int ADDR_W = 6;   // buffer address bus, enough for the largest group

   localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 7'd2;

   // request payload
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     final_element;
   } req_payload_type;

   // response payload
   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      logic                     run_end;
      logic                     sequence_end;
   } rsp_payload_type;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              run_end;
      logic              seq_end;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== design/kgrr_datapath.sv =====
// ----------------------------------------------------------------------------
// kgrr_datapath
// Group buffer memory with a registered read port that doubles as the
// response output register.
// ----------------------------------------------------------------------------
module kgrr_datapath #(
   parameter int MAX_GROUP  = 64,
   parameter int WORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kgrr_pkg::cmd_type                    cmd,
   output kgrr_pkg::status_type                 status,
   input  logic signed [kgrr_pkg::DATA_W-1:0]   wr_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output kgrr_pkg::rsp_payload_type            rsp_payload
);

   localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

   logic [WORD_WIDTH-1:0] mem [MAX_GROUP];
   logic [WORD_WIDTH-1:0] rd_word_ff;
   logic                  run_end_ff;
   logic                  seq_end_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   // buffer write, elements kept at the configured word width
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr[IDX_W-1:0]] <= WORD_WIDTH'($unsigned(wr_value));
      end
   end

   // registered read into the output stage, with run flags alongside
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_word_ff <= mem[cmd.rd_addr[IDX_W-1:0]];
         run_end_ff <= cmd.run_end;
         seq_end_ff <= cmd.seq_end;
      end
   end

   // output stage occupancy
   always_comb begin
      if (cmd.rd_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // slot can take a new entry when empty or being drained this cycle
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_payload.out_value    = $signed(kgrr_pkg::DATA_W'(rd_word_ff));
   assign rsp_payload.run_end      = run_end_ff;
   assign rsp_payload.sequence_end = seq_end_ff;

endmodule

// ===== design/kgrr_controller.sv =====
// ----------------------------------------------------------------------------
// kgrr_controller
// Group size register, fill counter and drain sequencer. Decides when a
// group is complete and walks the buffer backward (full group) or forward
// (leftover at end of sequence).
// ----------------------------------------------------------------------------
module kgrr_controller #(
   parameter int MAX_GROUP = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_final,
   input  logic                            csr_wr_en,
   input  logic [kgrr_pkg::CFG_W-1:0]      csr_wr_data,
   output kgrr_pkg::cmd_type               cmd,
   input  kgrr_pkg::status_type            status
);

   localparam int FW    = $clog2(MAX_GROUP + 1);
   localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam logic [kgrr_pkg::CFG_W-1:0] MAX_SIZE = kgrr_pkg::CFG_W'(MAX_GROUP);

   kgrr_pkg::ctrl_state_type state_ff, state_in;

   logic [kgrr_pkg::CFG_W-1:0] group_size_ff;
   logic [FW-1:0]              fill_ff, fill_in;
   logic [FW-1:0]              remain_ff, remain_in;
   logic [IDX_W-1:0]           ptr_ff, ptr_in;
   logic                       down_ff, down_in;
   logic                       seq_ff, seq_in;

   logic [kgrr_pkg::CFG_W-1:0] eff_size;
   logic [kgrr_pkg::CFG_W-1:0] new_fill;
   logic                       accept;
   logic                       last_issue;

   // group size register
   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= kgrr_pkg::GROUP_SIZE_RESET;
      end else if (csr_wr_en) begin
         group_size_ff <= csr_wr_data;
      end
   end

   // zero means pass-through, oversize saturates
   always_comb begin
      priority if (group_size_ff == '0) begin
         eff_size = kgrr_pkg::CFG_W'(1);
      end else if (group_size_ff > MAX_SIZE) begin
         eff_size = MAX_SIZE;
      end else begin
         eff_size = group_size_ff;
      end
   end

   assign req_stall  = (state_ff != kgrr_pkg::ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign new_fill   = kgrr_pkg::CFG_W'(fill_ff) + kgrr_pkg::CFG_W'(1);
   assign last_issue = (remain_ff == FW'(1));

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      remain_in = remain_ff;
      ptr_in    = ptr_ff;
      down_in   = down_ff;
      seq_in    = seq_ff;

      cmd.wr_en   = accept;
      cmd.wr_addr = kgrr_pkg::ADDR_W'(fill_ff);
      cmd.rd_en   = 1'b0;
      cmd.rd_addr = kgrr_pkg::ADDR_W'(ptr_ff);
      cmd.run_end = last_issue;
      cmd.seq_end = last_issue && seq_ff;

      unique case (state_ff)
         kgrr_pkg::ST_IDLE: begin
            if (accept) begin
               if (new_fill >= eff_size) begin
                  // full group, newest first
                  state_in  = kgrr_pkg::ST_DRAIN;
                  fill_in   = '0;
                  remain_in = FW'(new_fill);
                  ptr_in    = IDX_W'(fill_ff);
                  down_in   = 1'b1;
                  seq_in    = req_final;
               end else if (req_final) begin
                  // leftover, original order
                  state_in  = kgrr_pkg::ST_DRAIN;
                  fill_in   = '0;
                  remain_in = FW'(new_fill);
                  ptr_in    = '0;
                  down_in   = 1'b0;
                  seq_in    = 1'b1;
               end else begin
                  fill_in = FW'(new_fill);
               end
            end
         end
         kgrr_pkg::ST_DRAIN: begin
            if (status.out_free) begin
               cmd.rd_en = 1'b1;
               remain_in = remain_ff - FW'(1);
               ptr_in    = down_ff ? (ptr_ff - IDX_W'(1)) : (ptr_ff + IDX_W'(1));
               if (last_issue) begin
                  state_in = kgrr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = kgrr_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= kgrr_pkg::ST_IDLE;
         fill_ff   <= '0;
         remain_ff <= '0;
         ptr_ff    <= '0;
         down_ff   <= 1'b0;
         seq_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         remain_ff <= remain_in;
         ptr_ff    <= ptr_in;
         down_ff   <= down_in;
         seq_ff    <= seq_in;
      end
   end

endmodule

// ===== design/k_group_reversal_reorder.sv =====
// ----------------------------------------------------------------------------
// k_group_reversal_reorder
// Reverses a stream of words in groups of a configured size; a partial
// group left at the end of the sequence goes out in original order.
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall req_payload (value, final_element)
//   rsp_      out        rsp_valid/rsp_stall rsp_payload (out_value, run_end,
//                                                         sequence_end)
//   csr_      in         csr_wr_en           csr_wr_data (group_size)
//
// Requests are taken one per cycle while a group fills. The request that
// closes a group (or ends the sequence) holds req_stall high while the
// buffer drains through its single read port, one response per cycle
// while rsp_stall does not hold the output register.
// The last response of a run may still sit in the output register while
// the next request is taken. rsp_stall only pauses the drain.
// Synchronous reset clears the fill count and sets group size to 2; no
// buffer clearing pass is needed.
// ----------------------------------------------------------------------------
module k_group_reversal_reorder #(
   parameter int MAX_GROUP  = 64,
   parameter int WORD_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  kgrr_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output kgrr_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_wr_en,
   input  logic [kgrr_pkg::CFG_W-1:0]       csr_wr_data
);

   kgrr_pkg::cmd_type    cmd;
   kgrr_pkg::status_type status;

   // sequencer
   kgrr_controller #(
      .MAX_GROUP (MAX_GROUP)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_final   (req_payload.final_element),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

   // buffer and output stage
   kgrr_datapath #(
      .MAX_GROUP  (MAX_GROUP),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .wr_value    (req_payload.value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // a read is issued only into a free output slot
   a_rd_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> status.out_free)
      else $error("buffer read issued while output stage is stalled");

   // filling and draining never overlap
   a_wr_rd_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> !cmd.rd_en)
      else $error("buffer write during drain");

   // an issued read shows up as a response next cycle
   a_rd_to_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> rsp_valid)
      else $error("issued read did not reach the output");

   // sequence end only closes a run
   a_seq_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.sequence_end |-> rsp_payload.run_end)
      else $error("sequence end without run end");

endmodule
